@@ rtl/core/iqpd_pkg.sv @@
// ----------------------------------------------------------------------------
// iqpd_pkg
// Shared constants, codes and types of the IQ packet deframer.
// ----------------------------------------------------------------------------
package iqpd_pkg;

    localparam int NUM_DDC   = 8;
    localparam int BASE_PORT = 1035;

    // DDC index width: exactly what NUM_DDC needs
    localparam int DDC_AW = (NUM_DDC > 1) ? $clog2(NUM_DDC) : 1;

    // Port window [PORT_LO, PORT_HI), 17 bits so the top bound never wraps
    localparam logic [16:0] PORT_LO = 17'(BASE_PORT);
    localparam logic [16:0] PORT_HI = 17'(BASE_PORT + NUM_DDC);

    localparam logic [10:0] MAX_BYTES_RST = 11'd1500;
    localparam logic [10:0] POS_MAX       = 11'd2047;

    // header byte offsets
    localparam logic [10:0] POS_SEQ_LAST = 11'd3;
    localparam logic [10:0] POS_CNT_HI   = 11'd14;
    localparam logic [10:0] POS_CNT_LO   = 11'd15;
    localparam logic [10:0] POS_PAYLOAD  = 11'd16;
    localparam logic [18:0] HDR_BYTES    = 19'd16;

    // byte slot within a six-byte sample
    localparam logic [2:0] PHASE_LAST = 3'd5;

    typedef enum logic [1:0] {
        ST_SAMPLE   = 2'd0,
        ST_TOO_LONG = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]         ddc_number;
        logic signed [23:0] i_sample;
        logic signed [23:0] q_sample;
        logic [8:0]         sample_position;
        logic [15:0]        declared_count;
        t_status            status;
        logic               sequence_mismatch;
        logic               last_of_packet;
    } t_result;

    typedef struct packed {
        logic              en;
        logic [DDC_AW-1:0] addr;
    } t_seq_rd;

    typedef struct packed {
        logic              en;
        logic [DDC_AW-1:0] addr;
        logic [31:0]       data;
    } t_seq_wr;

endpackage

@@ rtl/core/iqpd_seq_mem.sv @@
// ----------------------------------------------------------------------------
// iqpd_seq_mem
// Expected sequence number per DDC: synchronous RAM with registered read,
// per-entry valid bits so unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module iqpd_seq_mem (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  iqpd_pkg::t_seq_rd i_rd,
    input  iqpd_pkg::t_seq_wr i_wr,
    output logic [31:0]      o_rd_data
);
    import iqpd_pkg::*;

    logic [31:0]        mem [NUM_DDC];
    logic [NUM_DDC-1:0] r_vld;
    logic [31:0]        r_rd_data;
    logic               r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= mem[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_vld <= r_vld[i_rd.addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : 32'd0;

endmodule

@@ rtl/core/iqpd_parser.sv @@
// ----------------------------------------------------------------------------
// iqpd_parser
// Per-byte header/payload decode. Launches the sequence read at start of
// packet, checks and writes back at header byte 3.
// ----------------------------------------------------------------------------
module iqpd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_start_of_packet,
    input  logic [15:0]       i_source_port,
    input  logic [10:0]       i_max_bytes,
    input  logic [31:0]       i_seq_rd_data,
    output iqpd_pkg::t_seq_rd o_seq_rd,
    output iqpd_pkg::t_seq_wr o_seq_wr,
    output logic              o_res_valid,
    output iqpd_pkg::t_result o_res
);
    import iqpd_pkg::*;

    logic [10:0]       r_pos,    n_pos;
    logic [23:0]       r_hdr,    n_hdr;
    logic [15:0]       r_count,  n_count;
    logic [15:0]       r_left,   n_left;
    logic [39:0]       r_part,   n_part;
    logic [DDC_AW-1:0] r_ddc,    n_ddc;
    logic              r_active, n_active;
    logic              r_mism,   n_mism;
    logic              r_done,   n_done;
    logic [2:0]        r_phase,  n_phase;

    logic              ddc_port;
    logic [16:0]       port_ext;
    logic [16:0]       port_off;
    logic              proceed;
    logic [10:0]       pos;
    logic [23:0]       hdr_cur;
    logic [31:0]       seq_full;
    logic [15:0]       cnt_full;
    logic [18:0]       pkt_len;
    logic [15:0]       idx_full;

    assign port_ext = {1'b0, i_source_port};
    assign port_off = port_ext - PORT_LO;
    assign ddc_port = (port_ext >= PORT_LO) && (port_ext < PORT_HI);

    always_comb begin
        n_pos    = r_pos;
        n_hdr    = r_hdr;
        n_count  = r_count;
        n_left   = r_left;
        n_part   = r_part;
        n_ddc    = r_ddc;
        n_active = r_active;
        n_mism   = r_mism;
        n_done   = r_done;
        n_phase  = r_phase;

        o_seq_rd    = '0;
        o_seq_wr    = '0;
        o_res_valid = 1'b0;
        o_res       = '0;

        proceed  = 1'b0;
        pos      = r_pos;
        hdr_cur  = r_hdr;
        seq_full = {r_hdr, i_data_byte};
        cnt_full = {r_count[15:8], i_data_byte};
        pkt_len  = HDR_BYTES + {1'b0, cnt_full, 2'b00} + {2'b00, cnt_full, 1'b0};
        idx_full = r_count - r_left;

        o_res.ddc_number        = 3'(r_ddc);
        o_res.declared_count    = r_count;
        o_res.sequence_mismatch = r_mism;
        o_res.status            = ST_SAMPLE;

        if (i_accept) begin
            if (i_start_of_packet) begin
                n_active = 1'b0;
                n_mism   = 1'b0;
                n_done   = 1'b0;
                if (ddc_port) begin
                    // new packet: clear per-packet state, fetch expected seq
                    proceed      = 1'b1;
                    n_active     = 1'b1;
                    n_ddc        = port_off[DDC_AW-1:0];
                    pos          = '0;
                    hdr_cur      = '0;
                    n_count      = '0;
                    n_left       = '0;
                    n_part       = '0;
                    o_seq_rd.en   = 1'b1;
                    o_seq_rd.addr = port_off[DDC_AW-1:0];
                end
            end else begin
                proceed = ddc_port && r_active;
            end

            if (proceed) begin
                if (pos <= POS_SEQ_LAST) begin
                    n_hdr = {hdr_cur[15:0], i_data_byte};
                    if (pos == POS_SEQ_LAST) begin
                        if (i_seq_rd_data != seq_full) begin
                            n_mism = 1'b1;
                        end
                        o_seq_wr.en   = 1'b1;
                        o_seq_wr.addr = r_ddc;
                        o_seq_wr.data = seq_full + 32'd1;
                    end
                end else if (pos == POS_CNT_HI) begin
                    n_count = {i_data_byte, 8'h00};
                end else if (pos == POS_CNT_LO) begin
                    n_count = cnt_full;
                    o_res.declared_count = cnt_full;
                    o_res.last_of_packet = 1'b1;
                    if (pkt_len > {8'd0, i_max_bytes}) begin
                        o_res_valid  = 1'b1;
                        o_res.status = ST_TOO_LONG;
                        n_done       = 1'b1;
                    end else if (cnt_full == 16'd0) begin
                        o_res_valid  = 1'b1;
                        o_res.status = ST_EMPTY;
                        n_done       = 1'b1;
                    end else begin
                        n_left  = cnt_full;
                        n_part  = '0;
                        n_phase = '0;
                    end
                end else if (pos >= POS_PAYLOAD && !r_done && r_left != 16'd0) begin
                    if (r_phase == PHASE_LAST) begin
                        // sixth byte: I is the older three bytes, Q the newer
                        o_res_valid           = 1'b1;
                        o_res.i_sample        = r_part[39:16];
                        o_res.q_sample        = {r_part[15:0], i_data_byte};
                        o_res.sample_position = idx_full[8:0];
                        o_res.last_of_packet  = (r_left == 16'd1);
                        n_left  = r_left - 16'd1;
                        n_done  = (r_left == 16'd1);
                        n_part  = '0;
                        n_phase = '0;
                    end else begin
                        n_part  = {r_part[31:0], i_data_byte};
                        n_phase = r_phase + 3'd1;
                    end
                end

                n_pos = (pos < POS_MAX) ? pos + 11'd1 : pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_hdr    <= '0;
            r_count  <= '0;
            r_left   <= '0;
            r_part   <= '0;
            r_ddc    <= '0;
            r_active <= 1'b0;
            r_mism   <= 1'b0;
            r_done   <= 1'b0;
            r_phase  <= '0;
        end else begin
            r_pos    <= n_pos;
            r_hdr    <= n_hdr;
            r_count  <= n_count;
            r_left   <= n_left;
            r_part   <= n_part;
            r_ddc    <= n_ddc;
            r_active <= n_active;
            r_mism   <= n_mism;
            r_done   <= n_done;
            r_phase  <= n_phase;
        end
    end

endmodule

@@ rtl/core/iq_packet_deframer_core.sv @@
// ----------------------------------------------------------------------------
// iq_packet_deframer_core
// A result word shows in the cycle after the byte that completes it. One
// byte word per cycle unless back-pressured; the sequence RAM is read once
// at start of packet and written back at header byte 3, so no port conflict
// stalls. Reset (sync, active low): control state cleared, max length back
// to 1500, sequence RAM valid bits cleared at once (no clearing pass).
// ----------------------------------------------------------------------------
module iq_packet_deframer_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_start_of_packet,
    input  logic [15:0]        i_source_port,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_ddc_number,
    output logic signed [23:0] o_i_sample,
    output logic signed [23:0] o_q_sample,
    output logic [8:0]         o_sample_position,
    output logic [15:0]        o_declared_count,
    output logic [1:0]         o_status,
    output logic               o_sequence_mismatch,
    output logic               o_last_of_packet,
    // max packet length register
    input  logic               i_cfg_wr_en,
    input  logic [10:0]        i_cfg_wr_data
);
    import iqpd_pkg::*;

    logic        in_accept;
    logic [10:0] r_max_bytes;
    logic        r_out_valid, n_out_valid;
    t_result     r_out;
    t_seq_rd     seq_rd;
    t_seq_wr     seq_wr;
    logic [31:0] seq_rd_data;
    logic        res_valid;
    t_result     res;

    // Output register frees itself when taken, so a new byte can enter in
    // the same cycle the held word leaves.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= MAX_BYTES_RST;
        end else if (i_cfg_wr_en) begin
            r_max_bytes <= i_cfg_wr_data;
        end
    end

    // Expected sequence per DDC
    iqpd_seq_mem u_seq_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (seq_rd),
        .i_wr      (seq_wr),
        .o_rd_data (seq_rd_data)
    );

    // Byte decode and per-packet state
    iqpd_parser u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_data_byte       (i_data_byte),
        .i_start_of_packet (i_start_of_packet),
        .i_source_port     (i_source_port),
        .i_max_bytes       (r_max_bytes),
        .i_seq_rd_data     (seq_rd_data),
        .o_seq_rd          (seq_rd),
        .o_seq_wr          (seq_wr),
        .o_res_valid       (res_valid),
        .o_res             (res)
    );

    // Result word register
    always_comb begin
        n_out_valid = r_out_valid;
        if (in_accept && res_valid) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_ddc_number        = r_out.ddc_number;
    assign o_i_sample          = r_out.i_sample;
    assign o_q_sample          = r_out.q_sample;
    assign o_sample_position   = r_out.sample_position;
    assign o_declared_count    = r_out.declared_count;
    assign o_status            = r_out.status;
    assign o_sequence_mismatch = r_out.sequence_mismatch;
    assign o_last_of_packet    = r_out.last_of_packet;

endmodule

@@ verif/iq_packet_deframer_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iq_packet_deframer_core_tb
// Drives datagram bytes into the deframer, one word per handshake. A
// cycle-level model of the byte parser predicts each result word, and every
// result is compared field by field. The run covers header parsing, sequence
// tracking per DDC, length rejection, empty packets and sample splitting,
// under random idling, back-pressure and several max-length settings.
// ----------------------------------------------------------------------------
module iq_packet_deframer_core_tb;
    import iqpd_pkg::*;

    localparam int SAMPLE_BYTES = 6;     // 3 bytes I + 3 bytes Q
    localparam int PHASE_WORDS  = 250;   // counted datagram bytes per random phase
    localparam int PRINT_CAP    = 200;   // keep the log readable on a bad run
    localparam int DRAIN_LIMIT  = 2000;  // cycles allowed for the last results

    // directed packet: seq 0, filler header, count 1, I = most negative,
    // Q = most positive
    localparam logic [175:0] DIRECTED_PKT =
        176'h00000000_FFFFFFFF_FFFFFFFF_FFFF_0001_800000_7FFFFF;

    typedef struct packed {
        logic [7:0]  data;
        logic        sop;
        logic [15:0] port;
    } dgram_word_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic               i_clk             = 1'b0;
    logic               i_rst_n           = 1'b0;
    logic               i_in_valid        = 1'b0;
    logic               o_in_ready;
    logic [7:0]         i_data_byte       = '0;
    logic               i_start_of_packet = 1'b0;
    logic [15:0]        i_source_port     = '0;
    logic               o_out_valid;
    logic               i_out_ready       = 1'b0;
    logic [2:0]         o_ddc_number;
    logic signed [23:0] o_i_sample;
    logic signed [23:0] o_q_sample;
    logic [8:0]         o_sample_position;
    logic [15:0]        o_declared_count;
    logic [1:0]         o_status;
    logic               o_sequence_mismatch;
    logic               o_last_of_packet;
    logic               i_cfg_wr_en       = 1'b0;
    logic [10:0]        i_cfg_wr_data     = '0;

    iq_packet_deframer_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_data_byte        (i_data_byte),
        .i_start_of_packet  (i_start_of_packet),
        .i_source_port      (i_source_port),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_ddc_number       (o_ddc_number),
        .o_i_sample         (o_i_sample),
        .o_q_sample         (o_q_sample),
        .o_sample_position  (o_sample_position),
        .o_declared_count   (o_declared_count),
        .o_status           (o_status),
        .o_sequence_mismatch(o_sequence_mismatch),
        .o_last_of_packet   (o_last_of_packet),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser model state: mirrors the block's registers after reset
    // ------------------------------------------------------------------
    logic [10:0] max_bytes_m = MAX_BYTES_RST;
    logic [31:0] seq_expect [NUM_DDC] = '{default: '0};
    logic [10:0] byte_pos    = '0;
    logic [31:0] hdr_seq     = '0;
    logic [15:0] count_m     = '0;
    logic [15:0] left_m      = '0;
    logic [39:0] partial_m   = '0;
    logic [2:0]  cur_ddc     = '0;
    logic        pkt_active  = 1'b0;
    logic        pkt_mismatch = 1'b0;
    logic        pkt_done    = 1'b0;

    t_result     expected_words [$];   // results predicted, not yet seen
    dgram_word_t tx_words [$];         // bytes waiting for the driver
    dgram_word_t cur_word;             // byte currently offered

    int words_queued   = 0;
    int words_accepted = 0;
    int results_seen   = 0;
    int mismatch_count = 0;

    // idling knobs, percent chance of a gap after each word sent or ready cycle
    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    int tx_gap_left  = 0;
    int rx_stall_left = 0;
    logic rx_hold = 1'b0;              // long receiver hold-off

    // stimulus-side forecast of the next sequence number per DDC, so most
    // packets carry a matching number
    logic [31:0] gen_seq [NUM_DDC] = '{default: '0};
    logic [10:0] gen_max = MAX_BYTES_RST;
    int          content_total = 0;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("%0t: error: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %h want %h",
                                      results_seen, name, got, want));
    endtask

    task automatic queue_result(input t_status st, input logic [23:0] iv,
                                input logic [23:0] qv, input logic [8:0] pos,
                                input logic last);
        t_result r;
        r = '0;
        r.ddc_number        = cur_ddc;
        r.i_sample          = iv;
        r.q_sample          = qv;
        r.sample_position   = pos;
        r.declared_count    = count_m;
        r.status            = st;
        r.sequence_mismatch = pkt_mismatch;
        r.last_of_packet    = last;
        expected_words.push_back(r);
    endtask

    // Byte parser: one accepted word in, at most one result predicted.
    task automatic deframe_byte(input dgram_word_t w);
        logic ddc_port;
        ddc_port = (int'(w.port) >= BASE_PORT) && (int'(w.port) < BASE_PORT + NUM_DDC);
        if (w.sop) begin
            // any start mark ends the current packet
            pkt_active   = 1'b0;
            pkt_mismatch = 1'b0;
            pkt_done     = 1'b0;
            if (!ddc_port)
                return;
            pkt_active = 1'b1;
            cur_ddc    = 3'(int'(w.port) - BASE_PORT);
            byte_pos   = '0;
            hdr_seq    = '0;
            count_m    = '0;
            left_m     = '0;
            partial_m  = '0;
        end else if (!ddc_port || !pkt_active) begin
            return;
        end

        if (byte_pos <= POS_SEQ_LAST) begin
            hdr_seq = {hdr_seq[23:0], w.data};
            if (byte_pos == POS_SEQ_LAST) begin
                // expected number moves on even after a mismatch
                if (seq_expect[cur_ddc] != hdr_seq)
                    pkt_mismatch = 1'b1;
                seq_expect[cur_ddc] = hdr_seq + 32'd1;
            end
        end else if (byte_pos == POS_CNT_HI) begin
            count_m = {w.data, 8'h00};
        end else if (byte_pos == POS_CNT_LO) begin
            count_m = {count_m[15:8], w.data};
            if (int'(HDR_BYTES) + SAMPLE_BYTES * int'(count_m) > int'(max_bytes_m)) begin
                queue_result(ST_TOO_LONG, '0, '0, '0, 1'b1);
                pkt_done = 1'b1;
            end else if (count_m == 16'd0) begin
                queue_result(ST_EMPTY, '0, '0, '0, 1'b1);
                pkt_done = 1'b1;
            end else begin
                left_m    = count_m;
                partial_m = '0;
            end
        end else if (byte_pos >= POS_PAYLOAD && !pkt_done && left_m != 16'd0) begin
            if ((byte_pos - POS_PAYLOAD) % SAMPLE_BYTES == PHASE_LAST) begin
                // sixth byte closes the sample: I from the top three bytes
                left_m = left_m - 16'd1;
                if (left_m == 16'd0)
                    pkt_done = 1'b1;
                queue_result(ST_SAMPLE, partial_m[39:16], {partial_m[15:0], w.data},
                             9'(count_m - left_m - 16'd1), left_m == 16'd0);
                partial_m = '0;
            end else begin
                partial_m = {partial_m[31:0], w.data};
            end
        end

        // position saturates instead of wrapping back into the header
        if (byte_pos != POS_MAX)
            byte_pos = byte_pos + 11'd1;
    endtask

    // gap length: mostly short, now and then long
    function automatic int pick_gap(input int pct);
        int r;
        if ($urandom_range(99) >= pct)
            return 0;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(2, 1);
        if (r < 95)
            return $urandom_range(8, 3);
        return $urandom_range(60, 20);
    endfunction

    // payload bytes lean toward the sign-boundary values
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] foreign_port();
        case ($urandom_range(3))
            0:       return 16'(BASE_PORT - 1);
            1:       return 16'(BASE_PORT + NUM_DDC);
            2:       return 16'($urandom_range(BASE_PORT - 1));
            default: return 16'($urandom_range(16'hFFFF, BASE_PORT + NUM_DDC));
        endcase
    endfunction

    task automatic push_word(input logic [7:0] data, input logic sop,
                             input logic [15:0] port);
        dgram_word_t w;
        w.data = data;
        w.sop  = sop;
        w.port = port;
        tx_words.push_back(w);
        words_queued++;
    endtask

    // One DDC datagram of len bytes. With noisy set, stray foreign bytes are
    // slipped in and a few bytes arrive tagged with another DDC port.
    task automatic push_datagram(input logic [15:0] port, input logic [31:0] seq,
                                 input logic [15:0] count, input int len,
                                 input logic noisy);
        logic [7:0]  b;
        logic [15:0] p;
        for (int k = 0; k < len; k++) begin
            if (k < 4)
                b = seq[31 - 8*k -: 8];
            else if (k == int'(POS_CNT_HI))
                b = count[15:8];
            else if (k == int'(POS_CNT_LO))
                b = count[7:0];
            else
                b = pick_byte();
            p = port;
            if (noisy && k > 0) begin
                if ($urandom_range(99) < 4)
                    push_word(pick_byte(), 1'b0, foreign_port());
                if ($urandom_range(99) < 4)
                    p = 16'(BASE_PORT + $urandom_range(NUM_DDC - 1));
            end
            push_word(b, k == 0, p);
        end
        content_total += len;
        if (len >= 4)
            gen_seq[int'(port) - BASE_PORT] = seq + 32'd1;
    endtask

    task automatic random_packet();
        int          kind;
        int          n;
        int          ddc;
        int          fit;
        int          cnt;
        int          payload;
        int          len;
        logic [31:0] seq;
        logic [15:0] p;
        kind = $urandom_range(99);
        if (kind < 6) begin
            // whole datagram from a foreign port: ends any packet, else ignored
            p = foreign_port();
            n = $urandom_range(20, 1);
            for (int k = 0; k < n; k++)
                push_word(pick_byte(), k == 0, p);
            return;
        end
        if (kind < 10) begin
            // stray bytes with no start mark
            n = $urandom_range(4, 1);
            for (int k = 0; k < n; k++)
                push_word(pick_byte(), 1'b0, $urandom_range(1) ? foreign_port()
                          : 16'(BASE_PORT + $urandom_range(NUM_DDC - 1)));
            return;
        end

        ddc = $urandom_range(NUM_DDC - 1);
        case ($urandom_range(19))
            0, 1:    seq = $urandom;
            2:       seq = 32'hFFFF_FFFF;   // next packet checks the wrap
            default: seq = gen_seq[ddc];
        endcase

        fit = (int'(gen_max) - int'(HDR_BYTES)) / SAMPLE_BYTES;
        kind = $urandom_range(99);
        if (kind < 10)
            cnt = 0;
        else if (kind < 70)
            cnt = $urandom_range(4, 1);
        else if (kind < 80)
            cnt = (fit <= 20) ? fit : $urandom_range(4, 1);
        else if (kind < 90)
            cnt = fit + 1;                   // one sample too many
        else
            cnt = $urandom_range(16'hFFFF);
        payload = (cnt <= fit) ? SAMPLE_BYTES * cnt : 0;

        len = int'(HDR_BYTES) + payload;
        if ($urandom_range(99) < 80)
            len += $urandom_range(3);        // trailing bytes get ignored
        else
            len = $urandom_range(len - 1, 1); // cut short
        push_datagram(16'(BASE_PORT + ddc), seq, 16'(cnt), len, 1'b1);
    endtask

    task automatic run_random(input int words);
        int stop;
        stop = content_total + words;
        while (content_total < stop)
            random_packet();
    endtask

    // everything accepted and answered, plus slack for the result register
    task automatic wait_idle();
        while (words_accepted != words_queued || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max_bytes(input logic [10:0] value);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        max_bytes_m = value;
        gen_max     = value;
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued bytes; each accepted word goes to the model
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                deframe_byte(cur_word);
                words_accepted++;
            end
            // a new word may go out only once the current one is taken
            if (!i_in_valid || o_in_ready) begin
                if (tx_gap_left > 0) begin
                    tx_gap_left--;
                    i_in_valid <= 1'b0;
                end else if (tx_words.size() != 0) begin
                    cur_word = tx_words.pop_front();
                    i_in_valid        <= 1'b1;
                    i_data_byte       <= cur_word.data;
                    i_start_of_packet <= cur_word.sop;
                    i_source_port     <= cur_word.port;
                    tx_gap_left = pick_gap(tx_gap_pct);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("result %0d with none expected, ddc %0d",
                                              results_seen, o_ddc_number));
                end else begin
                    t_result want;
                    want = expected_words.pop_front();
                    check_field("ddc_number", 32'(o_ddc_number), 32'(want.ddc_number));
                    check_field("i_sample", 32'(o_i_sample), 32'(want.i_sample));
                    check_field("q_sample", 32'(o_q_sample), 32'(want.q_sample));
                    check_field("sample_position", 32'(o_sample_position),
                                32'(want.sample_position));
                    check_field("declared_count", 32'(o_declared_count),
                                32'(want.declared_count));
                    check_field("status", 32'(o_status), 32'(want.status));
                    check_field("sequence_mismatch", 32'(o_sequence_mismatch),
                                32'(want.sequence_mismatch));
                    check_field("last_of_packet", 32'(o_last_of_packet),
                                32'(want.last_of_packet));
                end
                results_seen++;
            end
            if (rx_stall_left > 0) begin
                rx_stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !rx_hold;
                rx_stall_left = pick_gap(rx_stall_pct);
            end
        end
    end

    // Long receiver hold-off early in the run: the sender keeps offering, so
    // the block backs up and drops o_in_ready.
    initial begin
        while (words_accepted < 60)
            @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Hard limit on run time
    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: default max length of 1500
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        push_word(8'hA5, 1'b0, 16'(BASE_PORT));          // no packet open yet
        for (int k = 0; k < 22; k++) begin
            if (k == 19)
                push_word(8'h3C, 1'b0, foreign_port()); // foreign byte mid-packet
            // one payload byte tagged with a different DDC still counts
            push_word(DIRECTED_PKT[175 - 8*k -: 8], k == 0,
                      (k == 18) ? 16'(BASE_PORT + 3) : 16'(BASE_PORT));
        end
        gen_seq[0] = 32'd1;
        push_word(8'hEE, 1'b0, 16'(BASE_PORT));          // past the payload
        // 3-byte datagram: sequence neither checked nor updated
        push_word(8'h12, 1'b1, 16'(BASE_PORT + NUM_DDC - 1));
        push_word(8'h34, 1'b0, 16'(BASE_PORT + NUM_DDC - 1));
        push_word(8'h56, 1'b0, 16'(BASE_PORT + NUM_DDC - 1));
        // start on a foreign port closes the packet; following bytes ignored
        push_word(8'h00, 1'b1, 16'(BASE_PORT - 1));
        push_word(8'hFF, 1'b0, 16'(BASE_PORT - 1));
        push_word(8'h5A, 1'b0, 16'(BASE_PORT + NUM_DDC - 1));
        run_random(PHASE_WORDS);

        // Largest setting, no idling
        write_max_bytes(POS_MAX);
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        run_random(PHASE_WORDS);

        // Smallest setting: only empty packets pass
        write_max_bytes(11'(HDR_BYTES));
        tx_gap_pct   = 40;
        rx_stall_pct = 40;
        run_random(PHASE_WORDS);

        write_max_bytes(11'd40);
        tx_gap_pct   = 0;
        rx_stall_pct = 50;
        run_random(PHASE_WORDS);

        write_max_bytes(11'($urandom_range(int'(POS_MAX), int'(HDR_BYTES))));
        tx_gap_pct   = 30;
        rx_stall_pct = 0;
        run_random(PHASE_WORDS);

        // Drain
        while (words_accepted != words_queued)
            @(posedge i_clk);
        for (int c = 0; c < DRAIN_LIMIT && expected_words.size() != 0; c++)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (expected_words.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      expected_words.size()));

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/iqpd_pkg.sv
rtl/core/iqpd_seq_mem.sv
rtl/core/iqpd_parser.sv
rtl/core/iq_packet_deframer_core.sv
verif/iq_packet_deframer_core_tb.sv
